### rtl/core/dbli_pkg.sv
// shared constants, types and helpers for the drift bitmap longest island block
package dbli_pkg;

  localparam int unsigned RAW_W       = 27;
  localparam int unsigned POS_W       = 5;
  localparam int unsigned SCAN_BITS   = 20;
  localparam int unsigned LATE_START  = 18;
  localparam int unsigned EARLY_TRAIL = 8;
  localparam int unsigned HT_GAP_A    = 7;
  localparam int unsigned HT_GAP_B    = 15;
  localparam int unsigned FIRST_BIT   = 24;
  localparam int unsigned MIN_RUN     = 1;

  // candidate runs start at positions 2 .. LATE_START-1
  localparam int unsigned NCAND  = LATE_START - 2;
  localparam int unsigned GROUP  = 4;
  localparam int unsigned NGROUP = NCAND / GROUP;

  typedef logic [POS_W-1:0] pos_t;

  typedef struct packed {
    pos_t len;
    pos_t lead;
  } cand_t;

  // word bit holding scan position p, skipping the high-threshold bits
  function automatic int unsigned word_bit(int unsigned p);
    int unsigned b;
    if (p <= HT_GAP_A) begin
      b = FIRST_BIT + 1 - p;
    end else if (p <= HT_GAP_B) begin
      b = FIRST_BIT - p;
    end else begin
      b = FIRST_BIT - 1 - p;
    end
    return b;
  endfunction

  // b comes later in the scan, so it wins a tie
  function automatic cand_t pick_later(cand_t a, cand_t b);
    cand_t r;
    r = (b.len >= a.len) ? b : a;
    return r;
  endfunction

endpackage

### rtl/core/dbli_ifs.sv
// valid/ready channel interfaces for readout words and island results
interface dbli_in_if;
  logic                        valid;
  logic                        ready;
  logic [dbli_pkg::RAW_W-1:0]  raw_word;

  modport source (output valid, output raw_word, input ready);
  modport sink   (input valid, input raw_word, output ready);
endinterface

interface dbli_out_if;
  logic              valid;
  logic              ready;
  dbli_pkg::pos_t    leading_edge;
  dbli_pkg::pos_t    trailing_edge;

  modport source (output valid, output leading_edge, output trailing_edge, input ready);
  modport sink   (input valid, input leading_edge, input trailing_edge, output ready);
endinterface

### rtl/core/drift_bitmap_longest_island.sv
// top level: four-stage pipeline finding the longest island of set time bits
//
// in_ch carries one 27-bit readout word per transaction; out_ch returns one
// result per word, leading_edge and trailing_edge, in the same order.
// each word goes through four register stages: time-bit extraction, run
// length per candidate start (one priority encoder per start), a 16-to-4
// compare, then a 4-to-1 compare with the edge fixup into the output
// register. throughput is one word per cycle while out_ch is not stalled;
// the stages hold no state between words. every stage carries a valid
// bit and advances when the stage after it is empty or moving, so a
// stall on out_ch backs up stage by stage and in_ch drops ready only
// when all four stages are full. nothing is lost or repeated across a
// stall.
// reset (rst_n low at a clock edge) empties the pipeline; results in flight
// are discarded and in_ch is ready on the next cycle.
module drift_bitmap_longest_island (
  input logic             clk,
  input logic             rst_n,
  dbli_in_if.sink         in_ch,
  dbli_out_if.source      out_ch
);

  localparam int unsigned SB = dbli_pkg::SCAN_BITS;
  localparam int unsigned PW = dbli_pkg::POS_W;
  localparam int unsigned NC = dbli_pkg::NCAND;
  localparam int unsigned NG = dbli_pkg::NGROUP;
  localparam int unsigned GS = dbli_pkg::GROUP;

  logic a_vld_r, b_vld_r, c_vld_r, d_vld_r;
  logic a_adv, b_adv, c_adv, d_adv;

  // the last scan position is always clear, so only positions 1..SB-1 are kept
  logic [SB-1:1]          a_scan_r, a_scan_nxt;
  dbli_pkg::cand_t        b_cand_r [NC];
  dbli_pkg::cand_t        b_cand_nxt [NC];
  dbli_pkg::cand_t        c_cand_r [NG];
  dbli_pkg::cand_t        c_cand_nxt [NG];
  dbli_pkg::pos_t         d_lead_r, d_lead_nxt;
  dbli_pkg::pos_t         d_trail_r, d_trail_nxt;

  assign d_adv = !d_vld_r || out_ch.ready;
  assign c_adv = !c_vld_r || d_adv;
  assign b_adv = !b_vld_r || c_adv;
  assign a_adv = !a_vld_r || b_adv;
  assign in_ch.ready = a_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
      d_vld_r <= 1'b0;
    end else begin
      if (a_adv) a_vld_r <= in_ch.valid;
      if (b_adv) b_vld_r <= a_vld_r;
      if (c_adv) c_vld_r <= b_vld_r;
      if (d_adv) d_vld_r <= c_vld_r;
    end
  end

  // stage a: pull the time bits out of the word in scan order
  for (genvar p = 1; p < SB; p++) begin : g_scan
    localparam int unsigned WB = dbli_pkg::word_bit(p);
    assign a_scan_nxt[p] = in_ch.raw_word[WB];
  end

  always_ff @(posedge clk) begin
    if (a_adv && in_ch.valid) begin
      a_scan_r <= a_scan_nxt;
    end
  end

  // stage b: a run starts where a set bit follows a clear one; its end is the
  // first clear position after the start
  always_comb begin
    dbli_pkg::pos_t end_pos;
    dbli_pkg::pos_t len;
    for (int i = 0; i < NC; i++) begin
      end_pos = PW'(SB);
      for (int p = SB - 1; p > i + 2; p--) begin
        if (!a_scan_r[p]) end_pos = PW'(p);
      end
      len = end_pos - PW'(i + 2);
      if (a_scan_r[i + 2] && !a_scan_r[i + 1] && (len > PW'(dbli_pkg::MIN_RUN))) begin
        b_cand_nxt[i].len  = len;
        b_cand_nxt[i].lead = PW'(i + 2);
      end else begin
        b_cand_nxt[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv && a_vld_r) begin
      b_cand_r <= b_cand_nxt;
    end
  end

  // stage c: reduce each group of candidates, later start wins a tie
  always_comb begin
    dbli_pkg::cand_t best;
    for (int g = 0; g < NG; g++) begin
      best = b_cand_r[g * GS];
      for (int k = 1; k < GS; k++) begin
        best = dbli_pkg::pick_later(best, b_cand_r[g * GS + k]);
      end
      c_cand_nxt[g] = best;
    end
  end

  always_ff @(posedge clk) begin
    if (c_adv && b_vld_r) begin
      c_cand_r <= c_cand_nxt;
    end
  end

  // stage d: final pick and trailing edge
  always_comb begin
    dbli_pkg::cand_t best;
    dbli_pkg::pos_t  trail;
    best = c_cand_r[0];
    for (int g = 1; g < NG; g++) begin
      best = dbli_pkg::pick_later(best, c_cand_r[g]);
    end
    trail = best.lead + best.len - PW'(1);
    d_lead_nxt = best.lead;
    if ((best.len == '0) || (trail < PW'(dbli_pkg::EARLY_TRAIL))) begin
      d_trail_nxt = '0;
    end else begin
      d_trail_nxt = trail;
    end
  end

  always_ff @(posedge clk) begin
    if (d_adv && c_vld_r) begin
      d_lead_r  <= d_lead_nxt;
      d_trail_r <= d_trail_nxt;
    end
  end

  assign out_ch.valid         = d_vld_r;
  assign out_ch.leading_edge  = d_lead_r;
  assign out_ch.trailing_edge = d_trail_r;

endmodule

### verif/dbli_island_checker.sv
// checker: predicts the longest island per readout word and compares results
`timescale 1ns / 1ps

module dbli_island_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [dbli_pkg::RAW_W-1:0] in_raw_word,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  dbli_pkg::pos_t             out_leading_edge,
  input  dbli_pkg::pos_t             out_trailing_edge,
  output int                         mismatches,
  output int                         islands_pending
);

  localparam int unsigned RAW_W       = dbli_pkg::RAW_W;
  localparam int unsigned SCAN_BITS   = dbli_pkg::SCAN_BITS;
  localparam int unsigned MIN_RUN     = dbli_pkg::MIN_RUN;
  localparam int unsigned LATE_START  = dbli_pkg::LATE_START;
  localparam int unsigned EARLY_TRAIL = dbli_pkg::EARLY_TRAIL;

  typedef struct packed {
    dbli_pkg::pos_t lead;
    dbli_pkg::pos_t trail;
  } island_t;

  island_t expected_islands[$];

  function automatic island_t predict_island(input logic [RAW_W-1:0] word);
    logic [1:SCAN_BITS] scan;
    logic               armed;
    int unsigned        run_len;
    int unsigned        best_len;
    int unsigned        run_start;
    int unsigned        run_end;
    island_t            res;
    // time bits in scan order, high-threshold bits dropped, last position forced clear
    scan = {word[24:18], word[16:9], word[7:4], 1'b0};
    armed = 1'b0;
    run_len = 0;
    best_len = 0;
    run_start = 0;
    run_end = 0;
    res = '0;
    for (int p = 1; p <= SCAN_BITS; p++) begin
      if (!scan[p]) armed = 1'b1;
      if (armed) begin
        if (scan[p]) begin
          if (run_len == 0) run_start = p;
          run_end = p;
          run_len++;
        end else begin
          // later run wins a tie
          if (run_len > MIN_RUN && run_len >= best_len && run_start < LATE_START) begin
            best_len = run_len;
            res.lead = dbli_pkg::pos_t'(run_start);
            res.trail = dbli_pkg::pos_t'(run_end);
          end
          run_len = 0;
        end
      end
    end
    if (res.trail < EARLY_TRAIL) res.trail = '0;
    return res;
  endfunction

  initial begin
    mismatches = 0;
    islands_pending = 0;
  end

  always @(posedge clk) begin
    island_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_islands.push_back(predict_island(in_raw_word));
      end
      if (out_valid && out_ready) begin
        if (expected_islands.size() == 0) begin
          $display("%0t: unexpected result lead=%0d trail=%0d", $time,
                   out_leading_edge, out_trailing_edge);
          mismatches++;
        end else begin
          want = expected_islands.pop_front();
          if (out_leading_edge !== want.lead) begin
            $display("%0t: leading_edge mismatch expected=%0d actual=%0d", $time,
                     want.lead, out_leading_edge);
            mismatches++;
          end
          if (out_trailing_edge !== want.trail) begin
            $display("%0t: trailing_edge mismatch expected=%0d actual=%0d", $time,
                     want.trail, out_trailing_edge);
            mismatches++;
          end
        end
      end
      islands_pending = expected_islands.size();
    end
  end

endmodule

### verif/testbench.sv
// top: clock, reset, readout word stimulus, result back-pressure and verdict
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned RAW_W     = dbli_pkg::RAW_W;
  localparam int unsigned SCAN_BITS = dbli_pkg::SCAN_BITS;

  localparam int RANDOM_WORDS = 430;
  localparam int IDLE_LIMIT   = 1000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_OFF     = 80;

  logic clk;
  logic rst_n;
  int   mismatches;
  int   islands_pending;
  int   idle_cycles;

  dbli_in_if  in_ch ();
  dbli_out_if out_ch ();

  drift_bitmap_longest_island i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  dbli_island_checker i_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_ch.valid),
    .in_ready          (in_ch.ready),
    .in_raw_word       (in_ch.raw_word),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_leading_edge  (out_ch.leading_edge),
    .out_trailing_edge (out_ch.trailing_edge),
    .mismatches        (mismatches),
    .islands_pending   (islands_pending)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // pos is in scan order (position 1 first); spare fills bits 26,25,17,8,2,1,0
  function automatic logic [RAW_W-1:0] pack_word(input logic [1:SCAN_BITS] pos,
                                                 input logic [6:0] spare);
    return {spare[6:5], pos[1:7], spare[4], pos[8:15], spare[3], pos[16:20], spare[2:0]};
  endfunction

  // all clear or all set, then 1 to 4 random runs, each followed by a clear bit
  function automatic logic [RAW_W-1:0] island_word();
    logic [1:SCAN_BITS] pos;
    int unsigned        start;
    int unsigned        len;
    pos = '0;
    if ($urandom_range(0, 3) == 0) pos = '1;
    repeat ($urandom_range(1, 4)) begin
      start = $urandom_range(1, SCAN_BITS);
      len = $urandom_range(1, 9);
      for (int p = start; p < start + len && p <= SCAN_BITS; p++) pos[p] = 1'b1;
      if (start + len <= SCAN_BITS) pos[start + len] = 1'b0;
    end
    return pack_word(pos, 7'($urandom));
  endfunction

  task automatic send_word(input logic [RAW_W-1:0] word);
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.raw_word <= word;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic sender_gap(input int n);
    repeat (n) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      in_ch.raw_word <= RAW_W'($urandom);
    end
  endtask

  // receiver: changing stall modes plus one long hold-off to back the pipeline up
  initial begin
    int          mode;
    int unsigned pattern;
    out_ch.ready = 1'b0;
    pattern = 32'hB2C5_6E19;
    wait (rst_n === 1'b1);
    repeat (40) @(negedge clk) out_ch.ready <= 1'b1;
    repeat (HOLD_OFF) @(negedge clk) out_ch.ready <= 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(32, 96)) begin
        @(negedge clk);
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= 1'($urandom_range(0, 1));
          2: out_ch.ready <= ($urandom_range(0, 3) == 0);
          default: begin
            out_ch.ready <= pattern[0];
            pattern = {pattern[0], pattern[31:1]};
          end
        endcase
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    logic [RAW_W-1:0] directed_words[$];
    int               burst_left;
    int               sent;
    logic [RAW_W-1:0] word;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.raw_word = '0;

    // edge cases of the scan
    directed_words = '{
      '0,
      '1,
      pack_word('0, 7'b1100000),                   // unused top bits only
      pack_word('0, 7'b0011111),                   // high-threshold and low bits only
      pack_word(20'b11111111111111111110, '0),     // all time bits, last forced clear
      pack_word(20'b11100110000000000000, '0),     // leading ones never count
      pack_word(20'b01010101010101010101, '0),     // only single-bit runs
      pack_word(20'b01100000000000000000, '0),     // early trailing edge
      pack_word(20'b00000000000000000110, '0),     // starts too late
      pack_word(20'b00000000000000001110, '0),     // start 17, trail 19
      pack_word(20'b00000000000000000111, '0),     // runs into the forced clear
      pack_word(20'b01100000000000000011, '0),     // late run loses to early one
      pack_word(20'b01100110000000000000, '0),     // tie: later run wins
      pack_word(20'b00000011111000000000, '0),     // run across the first gap
      pack_word(20'b00000000000001111100, '0),     // run across the second gap
      pack_word(20'b01111111111111111100, '0),     // run from position 2 to 18
      pack_word(20'b01110011110011111000, '1),     // growing runs, all spare bits set
      pack_word(20'b01111100110011000000, '0),     // longest first
      pack_word(20'b00110000000000000011, 7'b1010101),
      pack_word(20'b10000000000000000000, '0),
      pack_word(20'b00000000000000000001, '0)
    };

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_words[i]) send_word(directed_words[i]);
    sender_gap(2);

    sent = 0;
    while (sent < RANDOM_WORDS) begin
      burst_left = $urandom_range(1, 24);
      while (burst_left > 0 && sent < RANDOM_WORDS) begin
        case ($urandom_range(0, 5))
          0:       word = RAW_W'($urandom);
          1:       word = RAW_W'($urandom | $urandom);
          2:       word = RAW_W'($urandom & $urandom);
          default: word = island_word();
        endcase
        send_word(word);
        burst_left--;
        sent++;
      end
      if ($urandom_range(0, 3) != 0) sender_gap($urandom_range(1, 12));
    end
    sender_gap(1);

    while (islands_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && islands_pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
